// File: sv/drlm_pkg.sv
// Package for the dirty-rectangle list merger.
// Holds default sizes, register indexes, command codes and the control structs.
// No dependencies.
package drlm_pkg;

    localparam int DEF_MAX_RECTS  = 8;
    localparam int DEF_COORD_BITS = 12;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_COORD_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] RST_SCREEN_WIDTH  = 13'd800;
    localparam logic [CFG_DATA_W-1:0] RST_SCREEN_HEIGHT = 13'd1280;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        WSRC_NB,
        WSRC_RD,
        WSRC_HULL_NB,
        WSRC_HULL_ACC
    } t_wsrc;

    typedef enum logic [1:0] {
        NB_HOLD,
        NB_LOAD,
        NB_HULL
    } t_nb_op;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_HULL
    } t_acc_op;

    typedef struct packed {
        t_nb_op  nb_op;
        t_acc_op acc_op;
        logic    wr_en;
        t_wsrc   wr_src;
        logic    cost_init;
        logic    cost_cmp;
        logic    out_en;
        logic    out_last;
        logic    out_empty;
    } t_dp_cmd;

    typedef struct packed {
        logic nb_ok;
        logic meet_nb;
        logic meet_acc;
    } t_dp_status;

endpackage

// File: sv/drlm_datapath.sv
// Datapath of the dirty-rectangle list merger: rectangle store, clamp, union,
// adjacency test, area-growth cost pipeline, output register. Uses drlm_pkg.
module drlm_datapath #(
    parameter int MAX_RECTS  = drlm_pkg::DEF_MAX_RECTS,
    parameter int COORD_BITS = drlm_pkg::DEF_COORD_BITS,
    parameter int IW         = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [drlm_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [drlm_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic signed [drlm_pkg::IN_COORD_W-1:0] i_x_left,
    input  logic signed [drlm_pkg::IN_COORD_W-1:0] i_y_top,
    input  logic signed [drlm_pkg::IN_COORD_W-1:0] i_x_right,
    input  logic signed [drlm_pkg::IN_COORD_W-1:0] i_y_bottom,
    input  drlm_pkg::t_dp_cmd                      i_cmd,
    input  logic [IW-1:0]                          i_rd_addr,
    input  logic [IW-1:0]                          i_wr_addr,
    output drlm_pkg::t_dp_status                   o_status,
    output logic [IW-1:0]                          o_best,
    output logic                                   o_valid,
    output logic [COORD_BITS-1:0]                  o_rect_x_left,
    output logic [COORD_BITS-1:0]                  o_rect_y_top,
    output logic [COORD_BITS-1:0]                  o_rect_x_right,
    output logic [COORD_BITS-1:0]                  o_rect_y_bottom,
    output logic                                   o_last_rect,
    output logic                                   o_list_empty
);
    import drlm_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int SW  = 18;
    localparam int LIM = 1 << CB;
    localparam int PW  = 2 * (CB + 1);

    typedef struct packed {
        logic [CB-1:0] l;
        logic [CB-1:0] t;
        logic [CB-1:0] r;
        logic [CB-1:0] b;
    } t_box;

    function automatic t_box f_hull(t_box p, t_box q);
        t_box o;
        o.l = (p.l < q.l) ? p.l : q.l;
        o.t = (p.t < q.t) ? p.t : q.t;
        o.r = (p.r > q.r) ? p.r : q.r;
        o.b = (p.b > q.b) ? p.b : q.b;
        return o;
    endfunction

    function automatic logic f_meet(t_box p, t_box q);
        logic [CB:0] pr1, qr1, pb1, qb1;
        pr1 = {1'b0, p.r} + 1'b1;
        qr1 = {1'b0, q.r} + 1'b1;
        pb1 = {1'b0, p.b} + 1'b1;
        qb1 = {1'b0, q.b} + 1'b1;
        return !((pr1 < {1'b0, q.l}) || (qr1 < {1'b0, p.l}) ||
                 (pb1 < {1'b0, q.t}) || (qb1 < {1'b0, p.t}));
    endfunction

    logic [CFG_DATA_W-1:0] r_scr_w, r_scr_h;
    t_box                  r_store [MAX_RECTS];
    t_box                  r_nb, r_acc;
    logic                  r_nb_ok;
    t_box                  rd, hull_nb, hull_acc, wr_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= RST_SCREEN_WIDTH;
            r_scr_h <= RST_SCREEN_HEIGHT;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_SCREEN_WIDTH) begin
                r_scr_w <= i_cfg_data;
            end else if (i_cfg_idx == REG_SCREEN_HEIGHT) begin
                r_scr_h <= i_cfg_data;
            end
        end
    end

    // Clamp of the incoming rectangle to the screen.
    logic signed [SW-1:0] x1, y1, x2, y2, w_s, h_s, x1c, y1c, x2c, y2c;
    logic                 clamp_ok;
    t_box                 clamp_box;

    always_comb begin
        x1  = SW'(i_x_left);
        y1  = SW'(i_y_top);
        x2  = SW'(i_x_right);
        y2  = SW'(i_y_bottom);
        w_s = $signed({{(SW - CFG_DATA_W){1'b0}}, r_scr_w});
        h_s = $signed({{(SW - CFG_DATA_W){1'b0}}, r_scr_h});
        if (w_s > SW'(LIM)) begin
            w_s = SW'(LIM);
        end
        if (h_s > SW'(LIM)) begin
            h_s = SW'(LIM);
        end
        x1c = (x1 < 0) ? '0 : x1;
        y1c = (y1 < 0) ? '0 : y1;
        x2c = (x2 >= w_s) ? w_s - SW'(1) : x2;
        y2c = (y2 >= h_s) ? h_s - SW'(1) : y2;
        clamp_ok = !((x1 > x2) || (y1 > y2)) && !((x1c > x2c) || (y1c > y2c));
        clamp_box.l = x1c[CB-1:0];
        clamp_box.t = y1c[CB-1:0];
        clamp_box.r = x2c[CB-1:0];
        clamp_box.b = y2c[CB-1:0];
    end

    assign rd       = r_store[i_rd_addr];
    assign hull_nb  = f_hull(rd, r_nb);
    assign hull_acc = f_hull(rd, r_acc);

    always_comb begin
        unique case (i_cmd.wr_src)
            WSRC_NB:       wr_data = r_nb;
            WSRC_RD:       wr_data = rd;
            WSRC_HULL_NB:  wr_data = hull_nb;
            WSRC_HULL_ACC: wr_data = hull_acc;
            default:       wr_data = r_nb;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_store[i_wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.nb_op)
            NB_LOAD: begin
                r_nb    <= clamp_box;
                r_nb_ok <= clamp_ok;
            end
            NB_HULL: r_nb <= hull_nb;
            default: ;
        endcase
        unique case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= rd;
            ACC_HULL: r_acc <= hull_acc;
            default:  ;
        endcase
    end

    assign o_status.nb_ok    = r_nb_ok;
    assign o_status.meet_nb  = f_meet(rd, r_nb);
    assign o_status.meet_acc = f_meet(rd, r_acc);

    // Area-growth cost: dimensions, then products, then compare.
    logic [CB:0]     r_hw, r_hh, r_ew, r_eh;
    logic [PW-1:0]   hprod, eprod;
    logic [31:0]     r_ha, r_ea, r_min_grow, cost;
    logic [IW-1:0]   r_best;

    always_ff @(posedge i_clk) begin
        r_hw <= {1'b0, hull_nb.r} - {1'b0, hull_nb.l} + 1'b1;
        r_hh <= {1'b0, hull_nb.b} - {1'b0, hull_nb.t} + 1'b1;
        r_ew <= {1'b0, rd.r} - {1'b0, rd.l} + 1'b1;
        r_eh <= {1'b0, rd.b} - {1'b0, rd.t} + 1'b1;
        r_ha <= 32'(hprod);
        r_ea <= 32'(eprod);
    end

    assign hprod = r_hw * r_hh;
    assign eprod = r_ew * r_eh;
    assign cost  = r_ha - r_ea;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cost_init) begin
            r_min_grow <= '1;
            r_best     <= '0;
        end else if (i_cmd.cost_cmp && (cost < r_min_grow)) begin
            r_min_grow <= cost;
            r_best     <= i_rd_addr;
        end
    end

    assign o_best = r_best;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.out_en;
        end
        if (i_cmd.out_en) begin
            o_rect_x_left   <= i_cmd.out_empty ? '0 : rd.l;
            o_rect_y_top    <= i_cmd.out_empty ? '0 : rd.t;
            o_rect_x_right  <= i_cmd.out_empty ? '0 : rd.r;
            o_rect_y_bottom <= i_cmd.out_empty ? '0 : rd.b;
            o_last_rect     <= i_cmd.out_last;
            o_list_empty    <= i_cmd.out_empty;
        end
    end

endmodule

// File: sv/drlm_ctrl.sv
// Controller of the dirty-rectangle list merger: sequences the absorb scan,
// compaction shifts, cost scan, pair collapse and drain. Uses drlm_pkg.
module drlm_ctrl #(
    parameter int MAX_RECTS = drlm_pkg::DEF_MAX_RECTS,
    parameter int IW        = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_command,
    input  drlm_pkg::t_dp_status i_status,
    input  logic [IW-1:0]        i_best,
    output drlm_pkg::t_dp_cmd    o_cmd,
    output logic [IW-1:0]        o_rd_addr,
    output logic [IW-1:0]        o_wr_addr
);
    import drlm_pkg::*;

    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_RECTS);
    localparam logic [CW-1:0] LASTC = CW'(MAX_RECTS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_ABS   = 4'd2;
    localparam logic [3:0] S_SHIFT = 4'd3;
    localparam logic [3:0] S_COST  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_MERGE = 4'd7;
    localparam logic [3:0] S_CLOAD = 4'd8;
    localparam logic [3:0] S_CSCAN = 4'd9;
    localparam logic [3:0] S_DRAIN = 4'd10;

    logic [3:0]    r_state, n_state, r_ret, n_ret;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_k, n_k, r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_ret   <= S_ABS;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_ret   <= n_ret;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_ret     = r_ret;
        o_cmd     = '0;
        o_cmd.nb_op  = NB_HOLD;
        o_cmd.acc_op = ACC_HOLD;
        o_cmd.wr_src = WSRC_NB;
        o_rd_addr = r_i[IW-1:0];
        o_wr_addr = r_i[IW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_i = '0;
                    if (i_command == CMD_DRAIN) begin
                        n_state = S_DRAIN;
                    end else begin
                        o_cmd.nb_op     = NB_LOAD;
                        o_cmd.cost_init = 1'b1;
                        n_state         = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_state = i_status.nb_ok ? S_ABS : S_IDLE;
            end
            S_ABS: begin
                if (r_i == r_cnt) begin
                    if (r_cnt != MAXC) begin
                        o_wr_addr    = r_cnt[IW-1:0];
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_src = WSRC_NB;
                        n_cnt        = r_cnt + 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_i     = '0;
                        n_state = S_COST;
                    end
                end else if (i_status.meet_nb) begin
                    o_cmd.nb_op = NB_HULL;
                    n_k         = r_i + 1'b1;
                    n_ret       = S_ABS;
                    n_state     = S_SHIFT;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_SHIFT: begin
                // Close the gap left by the removed entry, one word a cycle.
                if (r_k == r_cnt) begin
                    n_cnt   = r_cnt - 1'b1;
                    n_i     = '0;
                    n_state = r_ret;
                end else begin
                    o_rd_addr    = r_k[IW-1:0];
                    o_wr_addr    = IW'(r_k - 1'b1);
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_src = WSRC_RD;
                    n_k          = r_k + 1'b1;
                end
            end
            S_COST: n_state = S_MUL;
            S_MUL:  n_state = S_CMP;
            S_CMP: begin
                o_cmd.cost_cmp = 1'b1;
                if (r_i == LASTC) begin
                    n_state = S_MERGE;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_COST;
                end
            end
            S_MERGE: begin
                o_rd_addr    = i_best;
                o_wr_addr    = i_best;
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = WSRC_HULL_NB;
                n_i          = '0;
                n_state      = S_CLOAD;
            end
            S_CLOAD: begin
                if (r_i == r_cnt) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.acc_op = ACC_LOAD;
                    n_j          = r_i + 1'b1;
                    n_state      = S_CSCAN;
                end
            end
            S_CSCAN: begin
                if (r_j == r_cnt) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_CLOAD;
                end else begin
                    o_rd_addr = r_j[IW-1:0];
                    if (i_status.meet_acc) begin
                        o_cmd.acc_op = ACC_HULL;
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_src = WSRC_HULL_ACC;
                        n_k          = r_j + 1'b1;
                        n_ret        = S_CLOAD;
                        n_state      = S_SHIFT;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                o_cmd.out_en = 1'b1;
                if (r_cnt == '0) begin
                    o_cmd.out_empty = 1'b1;
                    o_cmd.out_last  = 1'b1;
                    n_state         = S_IDLE;
                end else if (r_i == r_cnt - 1'b1) begin
                    o_cmd.out_last = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_IDLE;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: sv/dirty_rect_list_merger_top.sv
// Top level of the dirty-rectangle list merger.
// Instantiates drlm_ctrl and drlm_datapath; uses drlm_pkg.
//
// Usage: a command word is taken when start is high and busy is low.
// An add (command 0) clamps the signed rectangle to the screen, drops it if
// inverted or empty, absorbs every stored rectangle it overlaps or touches and
// appends the union; on a full list it is unioned into the entry of least area
// growth and touching pairs are collapsed. An add gives no result.
// A drain (command 1) gives one result word per stored rectangle, in order,
// one per cycle through the output register, with last_rect on the final
// one, then clears the list; an empty list gives one word with list_empty set.
// Results are marked by o_valid for one cycle; the receiver cannot stall.
// Flow: a dropped add ends after the clamp check; any other add scans the
// stored entries one by one, shifts the list down after each absorb and then
// starts the scan over; a full list adds the cost scan, in which each entry
// passes through the cost, multiply and compare states in turn before the
// next one is read, then the pair collapse. A drain keeps busy high while it
// reads out the entries, and its last word appears as busy falls. The store
// is a register file read at one address a cycle, which sets the scan rate.
// Reset empties the list and loads the default screen size; configuration
// writes are registered and take effect in the following cycle.
module dirty_rect_list_merger_top #(
    parameter int MAX_RECTS  = drlm_pkg::DEF_MAX_RECTS,
    parameter int COORD_BITS = drlm_pkg::DEF_COORD_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_command,
    input  logic signed [drlm_pkg::IN_COORD_W-1:0] i_x_left,
    input  logic signed [drlm_pkg::IN_COORD_W-1:0] i_y_top,
    input  logic signed [drlm_pkg::IN_COORD_W-1:0] i_x_right,
    input  logic signed [drlm_pkg::IN_COORD_W-1:0] i_y_bottom,
    input  logic                                   i_cfg_we,
    input  logic [drlm_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [drlm_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic                                   o_valid,
    output logic [COORD_BITS-1:0]                  o_rect_x_left,
    output logic [COORD_BITS-1:0]                  o_rect_y_top,
    output logic [COORD_BITS-1:0]                  o_rect_x_right,
    output logic [COORD_BITS-1:0]                  o_rect_y_bottom,
    output logic                                   o_last_rect,
    output logic                                   o_list_empty
);
    import drlm_pkg::*;

    localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic [IW-1:0] rd_addr, wr_addr, best;

    drlm_ctrl #(
        .MAX_RECTS (MAX_RECTS),
        .IW        (IW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_command (i_command),
        .i_status  (status),
        .i_best    (best),
        .o_cmd     (cmd),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr)
    );

    drlm_datapath #(
        .MAX_RECTS  (MAX_RECTS),
        .COORD_BITS (COORD_BITS),
        .IW         (IW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_x_left        (i_x_left),
        .i_y_top         (i_y_top),
        .i_x_right       (i_x_right),
        .i_y_bottom      (i_y_bottom),
        .i_cmd           (cmd),
        .i_rd_addr       (rd_addr),
        .i_wr_addr       (wr_addr),
        .o_status        (status),
        .o_best          (best),
        .o_valid         (o_valid),
        .o_rect_x_left   (o_rect_x_left),
        .o_rect_y_top    (o_rect_y_top),
        .o_rect_x_right  (o_rect_x_right),
        .o_rect_y_bottom (o_rect_y_bottom),
        .o_last_rect     (o_last_rect),
        .o_list_empty    (o_list_empty)
    );

endmodule
